>>> sv/cpts_pkg.sv
// Shared types and constants for the clock page trim sweeper.
`timescale 1ns / 1ps
package cpts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_BATCH   = 64;
  localparam int FRAME_BITS  = 20;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int LIM_W       = 11;
  localparam int THR_W       = 20;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 20;
  // Standby threshold divisor is 8: a shift by three.
  localparam int WRITER_SHIFT = 3;

  // Item operation codes
  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_TOUCH = 2'd1,
    ACT_UNMAP = 2'd2,
    ACT_TRIM  = 2'd3
  } act_t;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_AGING     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ENTRIES   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTEMPTS  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BATCH     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd4;

  // Command from front to back
  typedef struct packed {
    act_t                  action;
    logic [IDX_W-1:0]      index;
    logic [FRAME_BITS-1:0] frame;
    logic                  writer;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      victim_index;
    logic [FRAME_BITS-1:0] victim_frame;
    logic [CNT_W-1:0]      batch_count;
    logic                  start_writer;
    logic                  last;
  } result_t;

  // Table entry word
  typedef struct packed {
    logic                  valid;
    logic                  accessed;
    logic [FRAME_BITS-1:0] frame;
  } entry_t;

  // Settings handed to the sweeper
  typedef struct packed {
    logic             aging;
    logic [LIM_W-1:0] entries;
    logic [LIM_W-1:0] attempts;
    logic [CNT_W-1:0] batch;
  } sweep_cfg_t;

endpackage

>>> sv/clock_page_trim_sweeper.sv
// Top level of the clock page trim sweeper.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | push / full         | action entry_index frame_number standby_count
//  result   | pop / empty         | found victim_index victim_frame batch_count
//           |                     | start_writer last
//  config   | cfg_we              | cfg_addr cfg_wdata
//
// Map and unmap are one table write; touch is one table read, then a write-back
// of the accessed bit if the entry is valid.
// A trim visits up to attempts entries: each visited entry is one table
// read then, for a valid entry, one write-back.
// After reset a clearing pass zeroes all TABLE_DEPTH (1024) table entries;
// up to two items queue meanwhile, then full stays high until it is done.
// Items queue two deep at the front and results two deep at the back, so
// either side may stall without stalling the other at once.
`timescale 1ns / 1ps
module clock_page_trim_sweeper
  import cpts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [FRAME_BITS-1:0] frame_number,
  input  logic [THR_W-1:0]      standby_count,
  output logic                  empty,
  input  logic                  pop,
  output logic                  found,
  output logic [IDX_W-1:0]      victim_index,
  output logic [FRAME_BITS-1:0] victim_frame,
  output logic [CNT_W-1:0]      batch_count,
  output logic                  start_writer,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sweep_cfg_t       cfg;
  logic [THR_W-1:0] threshold;
  cmd_t             cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  result_t          res_in;
  result_t          res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aging    <= 1'b1;
      cfg.entries  <= LIM_W'(1024);
      cfg.attempts <= LIM_W'(64);
      cfg.batch    <= CNT_W'(16);
      threshold    <= THR_W'(2048);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AGING:     cfg.aging    <= cfg_wdata[0];
        REG_ENTRIES:   cfg.entries  <= cfg_wdata[LIM_W-1:0];
        REG_ATTEMPTS:  cfg.attempts <= cfg_wdata[LIM_W-1:0];
        REG_BATCH:     cfg.batch    <= cfg_wdata[CNT_W-1:0];
        REG_THRESHOLD: threshold    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  cpts_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .entry_index   (entry_index),
    .frame_number  (frame_number),
    .standby_count (standby_count),
    .threshold     (threshold),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd),
    .cmd_empty     (cmd_empty)
  );

  cpts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Result queue
  cpts_fifo #(.DEPTH(2), .T(result_t)) u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign found        = res_out.found;
  assign victim_index = res_out.victim_index;
  assign victim_frame = res_out.victim_frame;
  assign batch_count  = res_out.batch_count;
  assign start_writer = res_out.start_writer;
  assign last         = res_out.last;

endmodule

>>> sv/cpts_fifo.sv
// Small synchronous queue used between the parts of the sweeper.
`timescale 1ns / 1ps
module cpts_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> sv/cpts_front.sv
// Front end: accepts items, classifies them and queues commands.
`timescale 1ns / 1ps
module cpts_front
  import cpts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [FRAME_BITS-1:0] frame_number,
  input  logic [THR_W-1:0]      standby_count,
  input  logic [THR_W-1:0]      threshold,
  input  logic                  cmd_pop,
  output cmd_t                  cmd,
  output logic                  cmd_empty
);

  cmd_t in_cmd;

  // Writer flag is only meaningful for trims
  always_comb begin
    in_cmd.action = act_t'(action);
    in_cmd.index  = entry_index;
    in_cmd.frame  = frame_number;
    in_cmd.writer = (act_t'(action) == ACT_TRIM) &&
                    (standby_count < (threshold >> WRITER_SHIFT));
  end

  cpts_fifo #(.DEPTH(2), .T(cmd_t)) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

endmodule

>>> sv/cpts_back.sv
// Back end: owns the page table and runs map, touch, unmap and trim sweeps.
`timescale 1ns / 1ps
module cpts_back
  import cpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sweep_cfg_t cfg,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       res_push,
  output result_t    res,
  input  logic       res_full
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TOUCH, S_ACK, S_STEP, S_EVAL, S_FIN
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] hand;
  logic [IDX_W-1:0] pos;
  logic [LIM_W-1:0] attempts;
  logic [CNT_W-1:0] count;
  logic             writer;
  logic [IDX_W-1:0] cur_idx;
  result_t          pend;

  entry_t           mem [TABLE_DEPTH];
  entry_t           rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic [LIM_W-1:0] n_eff;
  logic [CNT_W-1:0] blim;
  logic [LIM_W-1:0] pos_inc;
  logic [IDX_W-1:0] npos;
  logic             more;
  logic             is_victim;
  logic             eval_go;
  result_t          new_vic;

  // Clamp limits
  always_comb begin
    if (cfg.entries == '0) begin
      n_eff = LIM_W'(1);
    end else if (cfg.entries > LIM_W'(TABLE_DEPTH)) begin
      n_eff = LIM_W'(TABLE_DEPTH);
    end else begin
      n_eff = cfg.entries;
    end
    blim = (cfg.batch > CNT_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH) : cfg.batch;
  end

  // Next hand position and loop test
  assign pos_inc   = LIM_W'(pos) + 1'b1;
  assign npos      = (pos_inc >= n_eff) ? '0 : pos_inc[IDX_W-1:0];
  assign more      = (count < blim) && (attempts < cfg.attempts);
  assign is_victim = rdata.valid && !(cfg.aging && rdata.accessed);
  // A victim displaces the held one; wait for room when that needs a push
  assign eval_go   = !(is_victim && (count != '0) && res_full);

  always_comb begin
    new_vic.found        = 1'b1;
    new_vic.victim_index = pos;
    new_vic.victim_frame = rdata.frame;
    new_vic.batch_count  = count + 1'b1;
    new_vic.start_writer = writer;
    new_vic.last         = 1'b0;
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = rdata;
    mem_re    = 1'b0;
    mem_raddr = npos;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        cmd_pop   = !cmd_empty;
        mem_waddr = cmd.index;
        mem_raddr = cmd.index;
        if (!cmd_empty) begin
          unique case (cmd.action)
            ACT_MAP: begin
              mem_we    = 1'b1;
              mem_wdata = '{valid: 1'b1, accessed: 1'b1, frame: cmd.frame};
            end
            ACT_UNMAP: begin
              mem_we    = 1'b1;
              mem_wdata = '{valid: 1'b0, accessed: 1'b0, frame: cmd.frame};
            end
            ACT_TOUCH: mem_re = 1'b1;
            ACT_TRIM:  mem_re = 1'b0;
          endcase
        end
      end
      S_TOUCH: begin
        mem_waddr          = cur_idx;
        mem_we             = rdata.valid;
        mem_wdata.accessed = 1'b1;
      end
      S_ACK: begin
        res_push = !res_full;
        res.last = 1'b1;
      end
      S_STEP: begin
        mem_re = more;
      end
      S_EVAL: begin
        if (rdata.valid && eval_go) begin
          mem_we             = 1'b1;
          mem_wdata.accessed = 1'b0;
          mem_wdata.valid    = !is_victim;
        end
        res_push = is_victim && (count != '0) && !res_full;
        res      = pend;
      end
      S_FIN: begin
        res_push = !res_full;
        if (count == '0) begin
          res.start_writer = writer;
          res.last         = 1'b1;
        end else begin
          res      = pend;
          res.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Table storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      hand     <= '0;
      pos      <= '0;
      attempts <= '0;
      count    <= '0;
      writer   <= 1'b0;
      cur_idx  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cur_idx <= cmd.index;
            unique case (cmd.action)
              ACT_TOUCH: state <= S_TOUCH;
              ACT_TRIM: begin
                pos      <= hand;
                attempts <= '0;
                count    <= '0;
                writer   <= cmd.writer;
                state    <= S_STEP;
              end
              ACT_MAP, ACT_UNMAP: state <= S_ACK;
            endcase
          end
        end
        S_TOUCH: state <= S_ACK;
        S_ACK: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        S_STEP: begin
          if (more) begin
            pos      <= npos;
            attempts <= attempts + 1'b1;
            state    <= S_EVAL;
          end else begin
            state <= S_FIN;
          end
        end
        S_EVAL: begin
          if (eval_go) begin
            if (is_victim) begin
              pend  <= new_vic;
              count <= count + 1'b1;
            end
            state <= S_STEP;
          end
        end
        S_FIN: begin
          if (!res_full) begin
            if (count != '0) begin
              hand <= pos;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/cpts_checker.sv
// Port-level checks for the clock page trim sweeper, bound to the top level.
`timescale 1ns / 1ps
module cpts_checker
  import cpts_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  empty,
  input logic                  pop,
  input logic                  found,
  input logic [IDX_W-1:0]      victim_index,
  input logic [FRAME_BITS-1:0] victim_frame,
  input logic [CNT_W-1:0]      batch_count,
  input logic                  last
);

  // Nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A result without a victim always closes its item
  a_nofind_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> last)
    else $error("no-victim result without last");

  // A result without a victim carries zero index and count
  a_nofind_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (batch_count == '0 && victim_index == '0))
    else $error("no-victim result with nonzero payload");

  // A victim is counted and within the batch range
  a_vic_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && found) |-> (batch_count != '0 && batch_count <= CNT_W'(MAX_BATCH)))
    else $error("victim with bad batch count");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(victim_frame) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind clock_page_trim_sweeper cpts_checker u_cpts_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .found        (found),
  .victim_index (victim_index),
  .victim_frame (victim_frame),
  .batch_count  (batch_count),
  .last         (last)
);
